// ===== sv/sbpc_pkg.sv =====
// ============================================================================
// sbpc_pkg
// Shared types, constants and helpers for the swept box pair collision unit.
// ============================================================================
`default_nettype none

package sbpc_pkg;

    // Significant bits of every packed coordinate, held in the low bits of a
    // 16-bit lane.
    localparam int COORD_BITS = 16;
    localparam int LANE_BITS  = 16;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * EXT_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EXT_BITS-1:0]   ext_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_BOX  = 2'd1,
        CAUSE_PATH = 2'd2
    } cause_t;

    // Sign of one cross product, as seen by the path test.
    typedef struct packed {
        logic pos;
        logic zero;
    } cross_sign_t;

    // Lane idx of a packed word, as a signed coordinate (upper lane bits ignored).
    function automatic coord_t get_lane(input logic [63:0] word, input logic [1:0] idx);
        logic [5:0] base;
        base = {idx, 4'b0000};
        return coord_t'(word[base +: COORD_BITS]);
    endfunction

    // Inclusive overlap of two packed rectangles. A negative extent moves the
    // origin: the edges are simply min and max of x and x + w.
    function automatic logic rect_overlap(input logic [63:0] ra, input logic [63:0] rb);
        ext_t ax, ay, aw, ah, bx, by, bw, bh;
        ext_t axl, axr, ayl, ayr, bxl, bxr, byl, byr;
        ax  = ext_t'(get_lane(ra, 2'd0));
        ay  = ext_t'(get_lane(ra, 2'd1));
        aw  = ext_t'(get_lane(ra, 2'd2));
        ah  = ext_t'(get_lane(ra, 2'd3));
        bx  = ext_t'(get_lane(rb, 2'd0));
        by  = ext_t'(get_lane(rb, 2'd1));
        bw  = ext_t'(get_lane(rb, 2'd2));
        bh  = ext_t'(get_lane(rb, 2'd3));
        axl = aw[EXT_BITS-1] ? ax + aw : ax;
        axr = aw[EXT_BITS-1] ? ax      : ax + aw;
        ayl = ah[EXT_BITS-1] ? ay + ah : ay;
        ayr = ah[EXT_BITS-1] ? ay      : ay + ah;
        bxl = bw[EXT_BITS-1] ? bx + bw : bx;
        bxr = bw[EXT_BITS-1] ? bx      : bx + bw;
        byl = bh[EXT_BITS-1] ? by + bh : by;
        byr = bh[EXT_BITS-1] ? by      : by + bh;
        return (axr >= bxl) && (axl <= bxr) && (ayr >= byl) && (ayl <= byr);
    endfunction

endpackage

`default_nettype wire

// ===== sv/sbpc_cross.sv =====
// ============================================================================
// sbpc_cross
// Cross product of a motion segment against one point: both partial
// products registered, then compared to give the sign.
// ============================================================================
`default_nettype none

module sbpc_cross
    import sbpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire coord_t      ox,
    input  wire coord_t      oy,
    input  wire coord_t      opx,
    input  wire coord_t      opy,
    input  wire coord_t      px,
    input  wire coord_t      py,
    output cross_sign_t      sign
);

    ext_t  dx, dy, ex, ey;
    prod_t p1_next, p2_next;
    prod_t p1_reg, p2_reg;

    always_comb
    begin
        dx      = ext_t'(ox) - ext_t'(opx);
        dy      = ext_t'(oy) - ext_t'(opy);
        ex      = ext_t'(px) - ext_t'(ox);
        ey      = ext_t'(py) - ext_t'(oy);
        p1_next = prod_t'(dx) * prod_t'(ey);
        p2_next = prod_t'(dy) * prod_t'(ex);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // cross = p1 - p2
    assign sign.pos  = p1_reg > p2_reg;
    assign sign.zero = p1_reg == p2_reg;

endmodule

`default_nettype wire

// ===== sv/swept_box_pair_collision_unit.sv =====
// ============================================================================
// swept_box_pair_collision_unit
// Collision test for a pair of moving objects: box overlap first, then a
// motion segment crossing test where the sweep rectangles overlap.
// ============================================================================
// A pair is taken whenever start is high; busy is tied low, so one pair per
// clock is accepted without gaps. Each pair gives exactly one result on
// hit/cause, marked by a one-cycle strobe once it has passed the v0, v1 and v2
// valid registers, in input order. The receiver cannot stall the block and
// results are not held: a result must be captured in its strobe cycle. Three
// register ranks lie on the path: input capture, the cross product rank (two
// signed 17x17 multiplies per sign test, four tests), and the result register.
`default_nettype none

module swept_box_pair_collision_unit
    import sbpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] a_box,
    input  wire logic [63:0] a_sweep,
    input  wire logic [31:0] a_prev,
    input  wire logic [63:0] b_box,
    input  wire logic [63:0] b_sweep,
    input  wire logic [31:0] b_prev,
    output logic             strobe,
    output logic             hit,
    output logic [1:0]       cause
);

    // ------------------------------------------------------------------
    // Stage 0: input capture
    // ------------------------------------------------------------------
    logic        v0_reg, v1_reg, v2_reg;
    logic [63:0] a_box_reg, a_sweep_reg, b_box_reg, b_sweep_reg;
    logic [31:0] a_prev_reg, b_prev_reg;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_box_reg   <= a_box;
            a_sweep_reg <= a_sweep;
            a_prev_reg  <= a_prev;
            b_box_reg   <= b_box;
            b_sweep_reg <= b_sweep;
            b_prev_reg  <= b_prev;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: overlap tests, flat-motion test, cross product rank
    // ------------------------------------------------------------------
    coord_t ax, ay, apx, apy, bx, by, bpx, bpy;

    always_comb
    begin
        ax  = get_lane(a_box_reg, 2'd0);
        ay  = get_lane(a_box_reg, 2'd1);
        apx = get_lane({32'd0, a_prev_reg}, 2'd0);
        apy = get_lane({32'd0, a_prev_reg}, 2'd1);
        bx  = get_lane(b_box_reg, 2'd0);
        by  = get_lane(b_box_reg, 2'd1);
        bpx = get_lane({32'd0, b_prev_reg}, 2'd0);
        bpy = get_lane({32'd0, b_prev_reg}, 2'd1);
    end

    logic box_ovl_reg, sweep_ovl_reg, flat_reg;
    logic box_ovl_next, sweep_ovl_next, flat_next;

    // Both objects move along the same row and their x spans interleave.
    always_comb
    begin
        box_ovl_next   = rect_overlap(a_box_reg, b_box_reg);
        sweep_ovl_next = rect_overlap(a_sweep_reg, b_sweep_reg);
        flat_next      = (ay == apy) && (by == bpy) && (ay == by) &&
                         (ax > bpx) && (apx < bx);
    end

    always_ff @(posedge clk)
    begin
        if (v0_reg)
        begin
            box_ovl_reg   <= box_ovl_next;
            sweep_ovl_reg <= sweep_ovl_next;
            flat_reg      <= flat_next;
        end
    end

    // A's segment against B's end points, and B's segment against A's.
    cross_sign_t s_a_bprev, s_a_bcur, s_b_aprev, s_b_acur;

    sbpc_cross u_cross_a_bprev (
        .clk  (clk),
        .en   (v0_reg),
        .ox   (ax),
        .oy   (ay),
        .opx  (apx),
        .opy  (apy),
        .px   (bpx),
        .py   (bpy),
        .sign (s_a_bprev)
    );

    sbpc_cross u_cross_a_bcur (
        .clk  (clk),
        .en   (v0_reg),
        .ox   (ax),
        .oy   (ay),
        .opx  (apx),
        .opy  (apy),
        .px   (bx),
        .py   (by),
        .sign (s_a_bcur)
    );

    sbpc_cross u_cross_b_aprev (
        .clk  (clk),
        .en   (v0_reg),
        .ox   (bx),
        .oy   (by),
        .opx  (bpx),
        .opy  (bpy),
        .px   (apx),
        .py   (apy),
        .sign (s_b_aprev)
    );

    sbpc_cross u_cross_b_acur (
        .clk  (clk),
        .en   (v0_reg),
        .ox   (bx),
        .oy   (by),
        .opx  (bpx),
        .opy  (bpy),
        .px   (ax),
        .py   (ay),
        .sign (s_b_acur)
    );

    // ------------------------------------------------------------------
    // Stage 2: decision and result register
    // ------------------------------------------------------------------
    logic   straddle_a, straddle_b, paths_cross;
    cause_t cause_next, cause_reg;

    always_comb
    begin
        straddle_a  = s_a_bprev.pos != s_a_bcur.pos;
        straddle_b  = s_b_aprev.pos != s_b_acur.pos;
        // Collinear same-row motion counts as a crossing when spans interleave.
        paths_cross = (flat_reg && s_a_bprev.zero && s_a_bcur.zero) ||
                      (straddle_a && straddle_b);
        if (box_ovl_reg)
            cause_next = CAUSE_BOX;
        else if (sweep_ovl_reg && paths_cross)
            cause_next = CAUSE_PATH;
        else
            cause_next = CAUSE_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            cause_reg <= cause_next;
        end
    end

    assign strobe = v2_reg;
    assign cause  = cause_reg;
    assign hit    = cause_reg != CAUSE_NONE;

`ifndef SYNTHESIS
    // Every accepted pair gives its result strobe after the v0, v1 and v2 registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 strobe)
        else $error("result strobe missing three clocks after accept");

    // No strobe without an accepted pair behind it in the v0, v1 and v2 registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(accept, 3))
        else $error("result strobe without an accepted pair");

    // A box-overlap result must come from the registered box test.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && cause == CAUSE_BOX) |-> $past(box_ovl_reg))
        else $error("box cause without box overlap");
`endif

endmodule

`default_nettype wire
